FILE: sv/dssa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dssa_pkg;

    localparam logic [1:0] OP_PUSH    = 2'd0;
    localparam logic [1:0] OP_POP     = 2'd1;
    localparam logic [1:0] OP_PEEK    = 2'd2;
    localparam logic [1:0] OP_DISPLAY = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // result queue between the core and the output port
    localparam int QDEPTH = 4;
    localparam int QAW    = 2;
    localparam int QCW    = 3;

    typedef struct packed {
        logic [1:0]         req_type;
        logic               stack_sel;
        logic signed [31:0] push_value;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] data;
        logic               last;
    } rsp_t;

    typedef enum logic {
        S_IDLE,
        S_DISP
    } state_t;

endpackage

`default_nettype wire

FILE: sv/dssa_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module dssa_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic [AW-1:0]        waddr,
    input  wire logic signed [31:0]   wdata,
    input  wire logic                 re,
    input  wire logic [AW-1:0]        raddr,
    output logic signed [31:0]        rdata
);

    logic signed [31:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: sv/dssa_outq.sv
`timescale 1ns / 1ps
`default_nettype none

module dssa_outq (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      enq,
    input  wire dssa_pkg::rsp_t            enq_item,
    output logic [dssa_pkg::QCW-1:0]       q_count,
    output logic                           rsp_valid,
    input  wire logic                      rsp_ready,
    output dssa_pkg::rsp_t                 rsp
);

    dssa_pkg::rsp_t                 buf_reg [dssa_pkg::QDEPTH];
    logic [dssa_pkg::QAW-1:0]       head_reg, head_next;
    logic [dssa_pkg::QAW-1:0]       tail_reg, tail_next;
    logic [dssa_pkg::QCW-1:0]       cnt_reg, cnt_next;
    logic                           deq;

    assign deq       = rsp_valid && rsp_ready;
    assign rsp_valid = (cnt_reg != '0);
    assign rsp       = buf_reg[head_reg];
    assign q_count   = cnt_reg;

    always_comb
    begin
        head_next = deq ? head_reg + 1'b1 : head_reg;
        tail_next = enq ? tail_reg + 1'b1 : tail_reg;
        cnt_next  = cnt_reg + dssa_pkg::QCW'(enq) - dssa_pkg::QCW'(deq);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            buf_reg[tail_reg] <= enq_item;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(enq && cnt_reg == dssa_pkg::QCW'(dssa_pkg::QDEPTH)))
        else $error("result queue written while full");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= dssa_pkg::QCW'(dssa_pkg::QDEPTH))
        else $error("result queue count out of range");

    a_count_inc: assert property (@(posedge clk) disable iff (!rst_n)
        (enq && !deq) |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("result queue count did not advance");

endmodule

`default_nettype wire

FILE: sv/dual_stack_shared_array_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Signals                      Direction  Payload
// req       req_valid/req_ready/req      in         req_type, stack_sel, push_value
// rsp       rsp_valid/rsp_ready/rsp      out        status, data, last
//
// Push, and any request on an empty stack, is answered without an array read; its result is queued
// at the accept edge and shows on rsp the cycle after if the result queue was empty.
// Pop and peek make one synchronous read of the shared array and queue the registered read data.
// Display issues one array read per cycle while the result queue has room for its items.
// Reset clears both stack counts; array contents stay undefined until pushed.
// A full four-item result queue holds off new items and display reads.

module dual_stack_shared_array_unit #(
    parameter int DEPTH = 16
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    output logic                 req_ready,
    input  wire dssa_pkg::req_t  req,
    output logic                 rsp_valid,
    input  wire logic            rsp_ready,
    output dssa_pkg::rsp_t       rsp
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    dssa_pkg::state_t         state_reg, state_next;
    logic [CW-1:0]            cnt_lo_reg, cnt_lo_next;
    logic [CW-1:0]            cnt_hi_reg, cnt_hi_next;
    logic [AW-1:0]            ptr_reg, ptr_next;
    logic [CW-1:0]            rem_reg, rem_next;
    logic                     rdv_reg, rdv_next;
    logic                     rlast_reg, rlast_next;

    logic                     accept;
    logic [CW-1:0]            cnt_sel;
    logic [CW:0]              cnt_sum;
    logic [CW:0]              hi_top;
    logic [CW:0]              hi_push;
    logic [CW-1:0]            lo_top;
    logic                     is_full;

    logic                     mem_we;
    logic [AW-1:0]            mem_waddr;
    logic                     mem_re;
    logic [AW-1:0]            mem_raddr;
    logic signed [31:0]       mem_rdata;

    logic                     enq;
    dssa_pkg::rsp_t           enq_item;
    logic [dssa_pkg::QCW-1:0] q_count;
    logic                     q_room;
    logic                     disp_room;

    assign accept    = req_valid && req_ready;
    assign cnt_sel   = req.stack_sel ? cnt_hi_reg : cnt_lo_reg;
    assign cnt_sum   = {1'b0, cnt_lo_reg} + {1'b0, cnt_hi_reg};
    assign is_full   = (cnt_sum >= (CW+1)'(DEPTH));
    assign hi_top    = (CW+1)'(DEPTH) - {1'b0, cnt_hi_reg};
    assign hi_push   = hi_top - 1'b1;
    assign lo_top    = cnt_lo_reg - 1'b1;
    assign q_room    = (q_count < dssa_pkg::QCW'(dssa_pkg::QDEPTH));
    assign disp_room = ((q_count + dssa_pkg::QCW'(rdv_reg))
                        < dssa_pkg::QCW'(dssa_pkg::QDEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= dssa_pkg::S_IDLE;
            cnt_lo_reg <= '0;
            cnt_hi_reg <= '0;
            rdv_reg    <= 1'b0;
            rem_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_lo_reg <= cnt_lo_next;
            cnt_hi_reg <= cnt_hi_next;
            rdv_reg    <= rdv_next;
            rem_reg    <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg   <= ptr_next;
        rlast_reg <= rlast_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        cnt_lo_next = cnt_lo_reg;
        cnt_hi_next = cnt_hi_reg;
        ptr_next    = ptr_reg;
        rem_next    = rem_reg;
        rdv_next    = 1'b0;
        rlast_next  = rlast_reg;
        req_ready   = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = cnt_lo_reg[AW-1:0];
        mem_re      = 1'b0;
        mem_raddr   = ptr_reg;
        enq         = rdv_reg;
        enq_item    = '{status: dssa_pkg::ST_OK, data: mem_rdata, last: rlast_reg};

        unique case (state_reg)
            dssa_pkg::S_IDLE:
            begin
                // hold off while a read result is still on its way
                req_ready = !rdv_reg && q_room;
                if (accept)
                begin
                    if (req.req_type == dssa_pkg::OP_PUSH)
                    begin
                        enq      = 1'b1;
                        enq_item = '{status: is_full ? dssa_pkg::ST_FULL : dssa_pkg::ST_OK,
                                     data: '0, last: 1'b1};
                        if (!is_full)
                        begin
                            mem_we = 1'b1;
                            if (req.stack_sel)
                            begin
                                mem_waddr   = hi_push[AW-1:0];
                                cnt_hi_next = cnt_hi_reg + 1'b1;
                            end
                            else
                            begin
                                mem_waddr   = cnt_lo_reg[AW-1:0];
                                cnt_lo_next = cnt_lo_reg + 1'b1;
                            end
                        end
                    end
                    else if (cnt_sel == '0)
                    begin
                        enq      = 1'b1;
                        enq_item = '{status: dssa_pkg::ST_EMPTY, data: '0, last: 1'b1};
                    end
                    else if (req.req_type == dssa_pkg::OP_DISPLAY)
                    begin
                        // walk ascending array order for both stacks
                        ptr_next   = req.stack_sel ? hi_top[AW-1:0] : '0;
                        rem_next   = cnt_sel;
                        state_next = dssa_pkg::S_DISP;
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = req.stack_sel ? hi_top[AW-1:0] : lo_top[AW-1:0];
                        rdv_next   = 1'b1;
                        rlast_next = 1'b1;
                        if (req.req_type == dssa_pkg::OP_POP)
                        begin
                            if (req.stack_sel)
                            begin
                                cnt_hi_next = cnt_hi_reg - 1'b1;
                            end
                            else
                            begin
                                cnt_lo_next = cnt_lo_reg - 1'b1;
                            end
                        end
                    end
                end
            end
            dssa_pkg::S_DISP:
            begin
                if (disp_room)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = ptr_reg;
                    rdv_next   = 1'b1;
                    rlast_next = (rem_reg == CW'(1));
                    ptr_next   = ptr_reg + 1'b1;
                    rem_next   = rem_reg - 1'b1;
                    if (rem_reg == CW'(1))
                    begin
                        state_next = dssa_pkg::S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = dssa_pkg::S_IDLE;
            end
        endcase
    end

    dssa_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (req.push_value),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    dssa_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .enq       (enq),
        .enq_item  (enq_item),
        .q_count   (q_count),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    a_counts_fit: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_sum <= (CW+1)'(DEPTH))
        else $error("stacks overlap in shared array");

    a_ready_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        req_ready |-> (!rdv_reg && state_reg == dssa_pkg::S_IDLE))
        else $error("item taken while a read is outstanding");

    a_disp_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dssa_pkg::S_DISP) |-> (rem_reg != '0))
        else $error("display walk with nothing left");

    a_last_ends_disp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dssa_pkg::S_DISP && mem_re && rem_reg == CW'(1))
        |=> (rdv_reg && rlast_reg && state_reg == dssa_pkg::S_IDLE))
        else $error("display run not closed with last");

endmodule

`default_nettype wire
